// ===== rtl/core/spp_pkg.sv =====
package spp_pkg;

    localparam int ADDR_W       = 48;
    localparam int PAGE_W       = 48;
    localparam int PRED_W       = 49;
    localparam int CONF_W       = 8;
    localparam int KIND_W       = 2;
    localparam int SHIFT_W      = 6;
    localparam int LOOK_W       = 5;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;

    localparam int DEF_MAX_LOOKAHEAD = 16;
    localparam int DEF_STRIDE_LIMIT  = 256;

    localparam logic [KIND_W-1:0] KIND_RANDOM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEQ     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STRIDED = 2'd2;

    localparam logic [1:0] REG_PAGE_SHIFT = 2'd0;
    localparam logic [1:0] REG_MIN_CONF   = 2'd1;
    localparam logic [1:0] REG_LOOKAHEAD  = 2'd2;

    localparam logic [SHIFT_W-1:0] RST_PAGE_SHIFT = 6'd12;
    localparam logic [CONF_W-1:0]  RST_MIN_CONF   = 8'd2;
    localparam logic [LOOK_W-1:0]  RST_LOOKAHEAD  = 5'd4;

    typedef struct packed {
        logic [SHIFT_W-1:0] page_shift;
        logic [CONF_W-1:0]  conf_thresh;
        logic [LOOK_W-1:0]  lookahead;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CONF_W-1:0] confidence;
    } t_pat;

endpackage

// ===== rtl/core/spp_ifs.sv =====
interface spp_in_if;
    import spp_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] access_address;

    modport source (output valid, output access_address, input ready);
    modport sink   (input valid, input access_address, output ready);
endinterface

interface spp_out_if;
    import spp_pkg::*;

    logic              valid;
    logic              ready;
    logic [PRED_W-1:0] predicted_page;
    logic              has_prediction;
    logic [KIND_W-1:0] pattern_kind;
    logic [CONF_W-1:0] confidence_level;
    logic              last_of_run;

    modport source (output valid, output predicted_page, output has_prediction,
                    output pattern_kind, output confidence_level, output last_of_run,
                    input ready);
    modport sink   (input valid, input predicted_page, input has_prediction,
                    input pattern_kind, input confidence_level, input last_of_run,
                    output ready);
endinterface

// ===== rtl/core/spp_cfg_regs.sv =====
module spp_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [spp_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [spp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [spp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output spp_pkg::t_cfg                      o_cfg
);
    import spp_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_PAGE_SHIFT: n_cfg.page_shift  = pwdata[SHIFT_W-1:0];
                REG_MIN_CONF:   n_cfg.conf_thresh = pwdata[CONF_W-1:0];
                REG_LOOKAHEAD:  n_cfg.lookahead   = pwdata[LOOK_W-1:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_shift  <= RST_PAGE_SHIFT;
            r_cfg.conf_thresh <= RST_MIN_CONF;
            r_cfg.lookahead   <= RST_LOOKAHEAD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PAGE_SHIFT: prdata = APB_DATA_W'(r_cfg.page_shift);
            REG_MIN_CONF:   prdata = APB_DATA_W'(r_cfg.conf_thresh);
            REG_LOOKAHEAD:  prdata = APB_DATA_W'(r_cfg.lookahead);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;
endmodule

// ===== rtl/core/spp_tracker.sv =====
module spp_tracker #(
    parameter int MAX_LOOKAHEAD = spp_pkg::DEF_MAX_LOOKAHEAD,
    parameter int STRIDE_LIMIT  = spp_pkg::DEF_STRIDE_LIMIT,
    localparam int SW = $clog2(STRIDE_LIMIT),
    localparam int CW = $clog2(MAX_LOOKAHEAD + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  spp_pkg::t_cfg                 i_cfg,
    spp_in_if.sink                        i_acc,
    input  logic                          i_load_ok,
    output logic                          o_desc_valid,
    output logic [spp_pkg::PAGE_W-1:0]    o_page,
    output logic [SW-1:0]                 o_stride,
    output logic [CW-1:0]                 o_count,
    output spp_pkg::t_pat                 o_pat
);
    import spp_pkg::*;

    logic              r_in_valid;
    logic [PAGE_W-1:0] r_page;

    logic              r_have;
    logic [PAGE_W-1:0] r_prev;
    logic [KIND_W-1:0] r_kind;
    logic [SW-1:0]     r_stride;
    logic [CONF_W-1:0] r_conf;

    logic [KIND_W-1:0] n_kind;
    logic [SW-1:0]     n_stride;
    logic [CONF_W-1:0] n_conf;
    logic [CONF_W-1:0] conf_inc;
    logic [CONF_W-1:0] conf_dec;

    logic [PRED_W-1:0] diff;
    logic              d_one;
    logic              d_zero;
    logic              d_stride;
    logic              consume;
    logic              predict;

    assign consume     = r_in_valid && i_load_ok;
    assign i_acc.ready = !r_in_valid || consume;

    // page index is formed on capture; shifts of 48 or more give page 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_acc.ready) begin
            r_in_valid <= i_acc.valid;
        end
        if (i_acc.ready && i_acc.valid) begin
            r_page <= i_acc.access_address >> i_cfg.page_shift;
        end
    end

    assign diff     = {1'b0, r_page} - {1'b0, r_prev};
    assign d_one    = (diff == PRED_W'(1));
    assign d_zero   = (diff == '0);
    assign d_stride = !diff[PRED_W-1] && (diff >= PRED_W'(2)) &&
                      (diff < PRED_W'(STRIDE_LIMIT));
    assign conf_inc = (r_conf == '1) ? r_conf : r_conf + CONF_W'(1);
    assign conf_dec = (r_conf > CONF_W'(2)) ? r_conf - CONF_W'(2) : '0;

    always_comb begin
        n_kind   = r_kind;
        n_stride = r_stride;
        n_conf   = r_conf;
        if (r_have) begin
            priority if (d_one) begin
                if (r_kind == KIND_SEQ) begin
                    n_conf = conf_inc;
                end else begin
                    n_kind   = KIND_SEQ;
                    n_conf   = CONF_W'(1);
                    n_stride = SW'(1);
                end
            end else if (d_stride) begin
                if (r_kind == KIND_STRIDED && diff[SW-1:0] == r_stride) begin
                    n_conf = conf_inc;
                end else begin
                    n_kind   = KIND_STRIDED;
                    n_stride = diff[SW-1:0];
                    n_conf   = CONF_W'(1);
                end
            end else if (!d_zero) begin
                // backward or long jump: decay, fall back to random when weak
                n_conf = conf_dec;
                if (conf_dec < i_cfg.conf_thresh) begin
                    n_kind = KIND_RANDOM;
                end
            end else begin
                // same page: pattern held
                n_kind = r_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have   <= 1'b0;
            r_prev   <= '0;
            r_kind   <= KIND_RANDOM;
            r_stride <= '0;
            r_conf   <= '0;
        end else if (consume) begin
            r_have   <= 1'b1;
            r_prev   <= r_page;
            r_kind   <= n_kind;
            r_stride <= n_stride;
            r_conf   <= n_conf;
        end
    end

    assign predict = (n_conf >= i_cfg.conf_thresh) && (n_kind != KIND_RANDOM);

    always_comb begin
        if (!predict) begin
            o_count = '0;
        end else if (int'(i_cfg.lookahead) > MAX_LOOKAHEAD) begin
            o_count = CW'(MAX_LOOKAHEAD);
        end else begin
            o_count = CW'(i_cfg.lookahead);
        end
    end

    assign o_desc_valid   = r_in_valid;
    assign o_page         = r_page;
    assign o_stride       = n_stride;
    assign o_pat.kind       = n_kind;
    assign o_pat.confidence = n_conf;
endmodule

// ===== rtl/core/spp_emitter.sv =====
module spp_emitter #(
    parameter int MAX_LOOKAHEAD = spp_pkg::DEF_MAX_LOOKAHEAD,
    parameter int STRIDE_LIMIT  = spp_pkg::DEF_STRIDE_LIMIT,
    localparam int SW = $clog2(STRIDE_LIMIT),
    localparam int CW = $clog2(MAX_LOOKAHEAD + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_desc_valid,
    input  logic [spp_pkg::PAGE_W-1:0]    i_page,
    input  logic [SW-1:0]                 i_stride,
    input  logic [CW-1:0]                 i_count,
    input  spp_pkg::t_pat                 i_pat,
    output logic                          o_load_ok,
    spp_out_if.source                     o_pred
);
    import spp_pkg::*;

    logic              r_run_valid;
    logic [PRED_W-1:0] r_acc;
    logic [SW-1:0]     r_stride;
    logic [CW-1:0]     r_rem;
    logic              r_has;
    t_pat              r_pat;

    logic              r_out_valid;
    logic [PRED_W-1:0] r_out_page;
    logic              r_out_has;
    t_pat              r_out_pat;
    logic              r_out_last;

    logic              out_free;
    logic              fire;
    logic              last;
    logic              load;
    logic [PRED_W-1:0] n_acc;

    assign out_free  = !r_out_valid || o_pred.ready;
    assign fire      = r_run_valid && out_free;
    assign last      = (r_rem == CW'(1));
    assign o_load_ok = !r_run_valid || (fire && last);
    assign load      = o_load_ok && i_desc_valid;
    assign n_acc     = r_acc + PRED_W'(r_stride);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
        end else if (load) begin
            r_run_valid <= 1'b1;
        end else if (fire && last) begin
            r_run_valid <= 1'b0;
        end
        if (load) begin
            r_acc    <= PRED_W'(i_page);
            r_stride <= i_stride;
            // a status-only request still takes one result slot
            r_rem    <= (i_count == '0) ? CW'(1) : i_count;
            r_has    <= (i_count != '0);
            r_pat    <= i_pat;
        end else if (fire) begin
            r_acc <= n_acc;
            r_rem <= r_rem - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_pred.ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out_page <= r_has ? n_acc : '0;
            r_out_has  <= r_has;
            r_out_pat  <= r_pat;
            r_out_last <= last;
        end
    end

    assign o_pred.valid            = r_out_valid;
    assign o_pred.predicted_page   = r_out_page;
    assign o_pred.has_prediction   = r_out_has;
    assign o_pred.pattern_kind     = r_out_pat.kind;
    assign o_pred.confidence_level = r_out_pat.confidence;
    assign o_pred.last_of_run      = r_out_last;
endmodule

// ===== rtl/core/stride_page_prefetcher_unit.sv =====
// An accepted request is registered in the tracker and loaded into the output
//   sequencer, which registers one result per cycle unless o_pred.ready
//   is low, max(1, min(lookahead, MAX_LOOKAHEAD)) results per request, 1 for
//   status-only. Next request is taken while results are still being drained.
// Reset (i_rst_n, synchronous, active low) clears the pattern state and
//   loads page_shift 12, confidence threshold 2, lookahead 4.
module stride_page_prefetcher_unit #(
    parameter int MAX_LOOKAHEAD = spp_pkg::DEF_MAX_LOOKAHEAD,
    parameter int STRIDE_LIMIT  = spp_pkg::DEF_STRIDE_LIMIT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [spp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [spp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [spp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    spp_in_if.sink                         i_acc,
    spp_out_if.source                      o_pred
);
    import spp_pkg::*;

    localparam int SW = $clog2(STRIDE_LIMIT);
    localparam int CW = $clog2(MAX_LOOKAHEAD + 1);

    t_cfg              cfg;
    logic              load_ok;
    logic              desc_valid;
    logic [PAGE_W-1:0] desc_page;
    logic [SW-1:0]     desc_stride;
    logic [CW-1:0]     desc_count;
    t_pat              desc_pat;

    spp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    spp_tracker #(
        .MAX_LOOKAHEAD (MAX_LOOKAHEAD),
        .STRIDE_LIMIT  (STRIDE_LIMIT)
    ) u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_acc        (i_acc),
        .i_load_ok    (load_ok),
        .o_desc_valid (desc_valid),
        .o_page       (desc_page),
        .o_stride     (desc_stride),
        .o_count      (desc_count),
        .o_pat        (desc_pat)
    );

    spp_emitter #(
        .MAX_LOOKAHEAD (MAX_LOOKAHEAD),
        .STRIDE_LIMIT  (STRIDE_LIMIT)
    ) u_emitter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_page       (desc_page),
        .i_stride     (desc_stride),
        .i_count      (desc_count),
        .i_pat        (desc_pat),
        .o_load_ok    (load_ok),
        .o_pred       (o_pred)
    );
endmodule
